### rtl/tcpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// Operation codes, status codes and the per-request result record that the
// control logic passes to the output stage of the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // Operation codes carried in the request's mode field.
    localparam logic [1:0] MODE_ENQ_PRIO = 2'd0;
    localparam logic [1:0] MODE_ENQ_ORD  = 2'd1;
    localparam logic [1:0] MODE_DEQ      = 2'd2;

    // Status codes of a result.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Field widths of the stream ports.
    localparam int MODE_W = 2;
    localparam int TICKET_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 7;

    // Result of one request, apart from the ticket read from a store.
    typedef struct packed {
        logic                popped;      // a ticket was removed
        logic                is_priority; // removed ticket came from the priority store
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
    } res_info_t;

endpackage

### rtl/two_class_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Ticket queue with a priority and an ordinary class, each a FIFO in its
// own memory; dequeues always serve the priority class first.
// ----------------------------------------------------------------------------
// Every request (enqueue priority, enqueue ordinary, dequeue) yields exactly
// one result. A request is decided in the cycle it is accepted, and its result
// appears on the master side after the store's registered read port and the
// output register. Requests are taken one per cycle without
// gaps as long as results are taken; a result waiting on the master side still
// leaves room for one more request. Requests beyond the class depth are dropped
// and flagged as full, and a dequeue of an empty queue is flagged as empty.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module two_class_priority_queue #(
    parameter int CLASS_DEPTH = 32,
    parameter int TICKET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] ticket_number
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] out_ticket, [17:16] status,
                                   // [24:18] occupancy, [25] is_empty, zero above
    output logic        m_tuser    // [0] out_is_priority
);

    import tcpq_pkg::*;

    localparam int AW = $clog2(CLASS_DEPTH);
    localparam int IN_BITS = (TICKET_BITS < TICKET_W) ? TICKET_BITS : TICKET_W;

    logic                   s_accept;
    logic                   advance;
    logic [TICKET_BITS-1:0] ticket;
    res_info_t              info;

    logic                   prio_wr_en, ord_wr_en, prio_rd_en, ord_rd_en;
    logic [AW-1:0]          prio_wr_addr, ord_wr_addr, prio_rd_addr, ord_rd_addr;
    logic [TICKET_BITS-1:0] wr_data, prio_rd_data, ord_rd_data;

    logic                   pend_valid_reg;
    res_info_t              pend_info_reg;
    logic                   m_valid_reg;
    logic [TICKET_W-1:0]    m_ticket_reg;
    res_info_t              m_info_reg;
    logic [TICKET_W-1:0]    read_ticket;

    // The pending stage moves on whenever the output register is free or drains.
    assign advance  = pend_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !pend_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign ticket   = TICKET_BITS'(s_tdata[IN_BITS-1:0]);

    tcpq_ctrl #(
        .CLASS_DEPTH(CLASS_DEPTH),
        .TICKET_BITS(TICKET_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .mode        (s_tuser),
        .ticket      (ticket),
        .prio_wr_en  (prio_wr_en),
        .ord_wr_en   (ord_wr_en),
        .prio_wr_addr(prio_wr_addr),
        .ord_wr_addr (ord_wr_addr),
        .wr_data     (wr_data),
        .prio_rd_en  (prio_rd_en),
        .ord_rd_en   (ord_rd_en),
        .prio_rd_addr(prio_rd_addr),
        .ord_rd_addr (ord_rd_addr),
        .info        (info)
    );

    tcpq_store #(
        .DEPTH(CLASS_DEPTH),
        .WIDTH(TICKET_BITS)
    ) u_prio_store (
        .aclk   (aclk),
        .wr_en  (prio_wr_en),
        .wr_addr(prio_wr_addr),
        .wr_data(wr_data),
        .rd_en  (prio_rd_en),
        .rd_addr(prio_rd_addr),
        .rd_data(prio_rd_data)
    );

    tcpq_store #(
        .DEPTH(CLASS_DEPTH),
        .WIDTH(TICKET_BITS)
    ) u_ord_store (
        .aclk   (aclk),
        .wr_en  (ord_wr_en),
        .wr_addr(ord_wr_addr),
        .wr_data(wr_data),
        .rd_en  (ord_rd_en),
        .rd_addr(ord_rd_addr),
        .rd_data(ord_rd_data)
    );

    // Pending stage: holds the request while the store's registered read port delivers its data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (s_accept) begin
            pend_valid_reg <= 1'b1;
        end else if (advance) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_info_reg <= info;
        end
    end

    // Pick the removed ticket from the store of its class.
    always_comb begin
        if (!pend_info_reg.popped) begin
            read_ticket = '0;
        end else if (pend_info_reg.is_priority) begin
            read_ticket = TICKET_W'(prio_rd_data);
        end else begin
            read_ticket = TICKET_W'(ord_rd_data);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_ticket_reg <= read_ticket;
            m_info_reg   <= pend_info_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_info_reg.is_empty, m_info_reg.occupancy,
                       m_info_reg.status, m_ticket_reg};
    assign m_tuser  = m_info_reg.is_priority;

    // A pending result that cannot move stays pending.
    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !advance) |=> pend_valid_reg)
        else $error("pending result lost");

    // No request is taken while a pending result is stuck.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !advance) |-> !s_tready)
        else $error("request accepted over a stalled result");

    // A result without a removed ticket carries a zero ticket.
    a_zero_ticket: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_info_reg.popped) |-> ((m_ticket_reg == '0) && !m_tuser))
        else $error("ticket reported without a dequeue");

endmodule

### rtl/tcpq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_store
// Ticket store of one class: a simple dual-port memory with one write port
// and one read port whose data is registered.
// ----------------------------------------------------------------------------
module tcpq_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tcpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Head, tail and count registers of both classes. Decides each request in
// the cycle it is accepted, drives the store write and read ports and
// produces the result record.
// ----------------------------------------------------------------------------
module tcpq_ctrl #(
    parameter int CLASS_DEPTH = 32,
    parameter int TICKET_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [tcpq_pkg::MODE_W-1:0]     mode,
    input  logic [TICKET_BITS-1:0]          ticket,
    output logic                            prio_wr_en,
    output logic                            ord_wr_en,
    output logic [$clog2(CLASS_DEPTH)-1:0]  prio_wr_addr,
    output logic [$clog2(CLASS_DEPTH)-1:0]  ord_wr_addr,
    output logic [TICKET_BITS-1:0]          wr_data,
    output logic                            prio_rd_en,
    output logic                            ord_rd_en,
    output logic [$clog2(CLASS_DEPTH)-1:0]  prio_rd_addr,
    output logic [$clog2(CLASS_DEPTH)-1:0]  ord_rd_addr,
    output tcpq_pkg::res_info_t             info
);

    import tcpq_pkg::*;

    localparam int AW = $clog2(CLASS_DEPTH);
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(CLASS_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CLASS_DEPTH);

    logic [AW-1:0] prio_head_reg, prio_head_next;
    logic [AW-1:0] prio_tail_reg, prio_tail_next;
    logic [CW-1:0] prio_count_reg, prio_count_next;
    logic [AW-1:0] ord_head_reg, ord_head_next;
    logic [AW-1:0] ord_tail_reg, ord_tail_next;
    logic [CW-1:0] ord_count_reg, ord_count_next;

    logic          prio_push, ord_push, prio_pop, ord_pop;
    logic          prio_full, ord_full;
    logic [STATUS_W-1:0] dec_status;
    logic [CW:0]   occ_sum;

    // Decide the request from the mode and the class counts.
    always_comb begin
        prio_full = (prio_count_reg == FULL_CNT);
        ord_full  = (ord_count_reg == FULL_CNT);
        prio_push = 1'b0;
        ord_push  = 1'b0;
        prio_pop  = 1'b0;
        ord_pop   = 1'b0;
        dec_status = STAT_OK;
        case (mode)
            MODE_ENQ_PRIO: begin
                if (prio_full) begin
                    dec_status = STAT_FULL;
                end else begin
                    prio_push = accept;
                end
            end
            MODE_ENQ_ORD: begin
                if (ord_full) begin
                    dec_status = STAT_FULL;
                end else begin
                    ord_push = accept;
                end
            end
            MODE_DEQ: begin
                if (prio_count_reg != '0) begin
                    prio_pop = accept;
                end else if (ord_count_reg != '0) begin
                    ord_pop = accept;
                end else begin
                    dec_status = STAT_EMPTY;
                end
            end
            default: begin
                // Unused mode code: no operation.
            end
        endcase
    end

    // Pointer and count updates; pointers wrap at the class depth.
    always_comb begin
        prio_head_next  = prio_head_reg;
        prio_tail_next  = prio_tail_reg;
        prio_count_next = prio_count_reg;
        ord_head_next   = ord_head_reg;
        ord_tail_next   = ord_tail_reg;
        ord_count_next  = ord_count_reg;
        if (prio_push) begin
            prio_tail_next  = (prio_tail_reg == LAST_PTR) ? '0 : prio_tail_reg + 1'b1;
            prio_count_next = prio_count_reg + 1'b1;
        end
        if (prio_pop) begin
            prio_head_next  = (prio_head_reg == LAST_PTR) ? '0 : prio_head_reg + 1'b1;
            prio_count_next = prio_count_reg - 1'b1;
        end
        if (ord_push) begin
            ord_tail_next  = (ord_tail_reg == LAST_PTR) ? '0 : ord_tail_reg + 1'b1;
            ord_count_next = ord_count_reg + 1'b1;
        end
        if (ord_pop) begin
            ord_head_next  = (ord_head_reg == LAST_PTR) ? '0 : ord_head_reg + 1'b1;
            ord_count_next = ord_count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_head_reg  <= '0;
            prio_tail_reg  <= '0;
            prio_count_reg <= '0;
            ord_head_reg   <= '0;
            ord_tail_reg   <= '0;
            ord_count_reg  <= '0;
        end else begin
            prio_head_reg  <= prio_head_next;
            prio_tail_reg  <= prio_tail_next;
            prio_count_reg <= prio_count_next;
            ord_head_reg   <= ord_head_next;
            ord_tail_reg   <= ord_tail_next;
            ord_count_reg  <= ord_count_next;
        end
    end

    // Occupancy after the request, as the result reports it.
    always_comb begin
        occ_sum = {1'b0, prio_count_next} + {1'b0, ord_count_next};
        info.popped      = prio_pop | ord_pop;
        info.is_priority = prio_pop;
        info.status      = dec_status;
        info.occupancy   = OCC_W'(occ_sum);
        info.is_empty    = (occ_sum == '0);
    end

    // Store ports: enqueues write at the tail, dequeues read at the head.
    assign prio_wr_en   = prio_push;
    assign ord_wr_en    = ord_push;
    assign prio_wr_addr = prio_tail_reg;
    assign ord_wr_addr  = ord_tail_reg;
    assign wr_data      = ticket;
    assign prio_rd_en   = prio_pop;
    assign ord_rd_en    = ord_pop;
    assign prio_rd_addr = prio_head_reg;
    assign ord_rd_addr  = ord_head_reg;

    // A class never holds more tickets than its store has entries.
    a_prio_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        prio_count_reg <= FULL_CNT)
        else $error("priority count exceeds class depth");

    a_ord_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ord_count_reg <= FULL_CNT)
        else $error("ordinary count exceeds class depth");

    // Tail leads head by the count, modulo the depth: equal pointers when the class is empty or full.
    a_prio_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        ((prio_count_reg == '0) || (prio_count_reg == FULL_CNT)) |->
            (prio_head_reg == prio_tail_reg))
        else $error("priority pointers disagree with count");

    // A dequeue while priority tickets are waiting leaves the ordinary class alone.
    a_strict_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (mode == MODE_DEQ) && (prio_count_reg != '0)) |=>
            ($stable(ord_count_reg) && $stable(ord_head_reg)))
        else $error("ordinary ticket served ahead of priority ticket");

endmodule

### sim/tb_two_class_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue
// Self-checking testbench for the two-class strict-priority ticket queue.
// ----------------------------------------------------------------------------
// A behavioral model keeps one ticket list per class and works out the result
// of every accepted request. Each result taken from the master side is checked
// field by field against the oldest outstanding prediction. Directed requests
// cover the ticket extremes, every operation, the no-operation mode, a dequeue
// of an empty queue and enqueues into a full class. Random bursts that lean
// toward filling, draining or neither follow in three phases; both sides of
// the stream idle at random in the first two phases and never in the last.
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue;
    import tcpq_pkg::*;

    localparam int          CLASS_DEPTH = 32;
    localparam logic [1:0]  MODE_NOP    = 2'd3;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          DRAIN_WAIT  = 12;
    localparam int          MAX_REPORTS = 10;

    // One result of the queue as it travels on the master side.
    typedef struct packed {
        logic [15:0] ticket;
        logic        is_priority;
        logic [1:0]  status;
        logic [6:0]  occupancy;
        logic        is_empty;
    } queue_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // Behavioral copy of the two class stores.
    logic [15:0] priority_tickets[$];
    logic [15:0] ordinary_tickets[$];

    queue_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    two_class_priority_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compute the result of one request and update the class lists.
    function automatic queue_result_t apply_queue_op(input logic [1:0] mode,
                                                     input logic [15:0] ticket);
        queue_result_t res;
        int            occ;
        res = '0;
        res.status = STAT_OK;
        case (mode)
            MODE_ENQ_PRIO: begin
                if (priority_tickets.size() >= CLASS_DEPTH) res.status = STAT_FULL;
                else priority_tickets.push_back(ticket);
            end
            MODE_ENQ_ORD: begin
                if (ordinary_tickets.size() >= CLASS_DEPTH) res.status = STAT_FULL;
                else ordinary_tickets.push_back(ticket);
            end
            MODE_DEQ: begin
                if (priority_tickets.size() > 0) begin
                    res.ticket = priority_tickets.pop_front();
                    res.is_priority = 1'b1;
                end else if (ordinary_tickets.size() > 0) begin
                    res.ticket = ordinary_tickets.pop_front();
                end else begin
                    res.status = STAT_EMPTY;
                end
            end
            default: begin
                // No-operation: only the occupancy is reported.
            end
        endcase
        occ = priority_tickets.size() + ordinary_tickets.size();
        res.occupancy = occ[6:0];
        res.is_empty = (occ == 0);
        return res;
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        queue_result_t exp_res;
        queue_result_t got_res;
        if (aresetn && m_tvalid && m_tready) begin
            got_res.ticket = m_tdata[15:0];
            got_res.status = m_tdata[17:16];
            got_res.occupancy = m_tdata[24:18];
            got_res.is_empty = m_tdata[25];
            got_res.is_priority = m_tuser;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no request outstanding: ticket %h", $realtime,
                             got_res.ticket);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res.ticket !== exp_res.ticket ||
                    got_res.is_priority !== exp_res.is_priority ||
                    got_res.status !== exp_res.status ||
                    got_res.occupancy !== exp_res.occupancy ||
                    got_res.is_empty !== exp_res.is_empty) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch: expected ticket %h prio %b status %0d occ %0d empty %b",
                                 $realtime, exp_res.ticket, exp_res.is_priority,
                                 exp_res.status, exp_res.occupancy, exp_res.is_empty);
                        $display("%0t: mismatch: got      ticket %h prio %b status %0d occ %0d empty %b",
                                 $realtime, got_res.ticket, got_res.is_priority,
                                 got_res.status, got_res.occupancy, got_res.is_empty);
                    end
                end
            end
        end
    end

    // Send one request and record its predicted result once it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [15:0] ticket);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= ticket;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_queue_op(mode, ticket));
    endtask

    // Hold off the sender until every outstanding result has arrived.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_ticket();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // Ticket extremes, class ordering, empty dequeue and no-operation.
    task automatic test_basic_ops();
        send_request(MODE_DEQ, 16'hFFFF);
        send_request(MODE_NOP, 16'hA5A5);
        send_request(MODE_ENQ_ORD, 16'h0000);
        send_request(MODE_ENQ_ORD, 16'hFFFF);
        send_request(MODE_ENQ_PRIO, 16'hFFFF);
        send_request(MODE_ENQ_PRIO, 16'h0001);
        send_request(MODE_NOP, 16'hFFFF);
        send_request(MODE_ENQ_PRIO, 16'h8000);
        send_request(MODE_DEQ, 16'h1234);
        send_request(MODE_ENQ_ORD, 16'h7FFF);
        send_request(MODE_DEQ, 16'h0000);
        send_request(MODE_DEQ, 16'h0000);
        send_request(MODE_DEQ, 16'h0000);
        send_request(MODE_DEQ, 16'h0000);
        send_request(MODE_DEQ, 16'h0000);
        send_request(MODE_DEQ, 16'h0000);
    endtask

    // Fill both classes past their depth, pause, then drain past empty.
    task automatic test_full_classes();
        for (int i = 0; i < CLASS_DEPTH + 2; i++) send_request(MODE_ENQ_ORD, pick_ticket());
        for (int i = 0; i < CLASS_DEPTH + 2; i++) send_request(MODE_ENQ_PRIO, pick_ticket());
        wait_results_drained();
        send_request(MODE_NOP, pick_ticket());
        for (int i = 0; i < 2 * CLASS_DEPTH + 2; i++) send_request(MODE_DEQ, pick_ticket());
    endtask

    // Random bursts that lean toward filling, draining or neither.
    task automatic test_random_bursts(input int num_requests);
        int sent;
        int lean;
        int burst_len;
        int prio_share;
        int r;
        sent = 0;
        while (sent < num_requests) begin
            lean = $urandom_range(2);
            burst_len = $urandom_range(8, 70);
            prio_share = $urandom_range(100);
            for (int i = 0; i < burst_len && sent < num_requests; i++) begin
                r = $urandom_range(99);
                if (r < 2) begin
                    send_request(MODE_NOP, pick_ticket());
                end else if ((lean == 0 && r < 80) || (lean == 1 && r < 27) ||
                             (lean == 2 && r < 51)) begin
                    if ($urandom_range(99) < prio_share)
                        send_request(MODE_ENQ_PRIO, pick_ticket());
                    else
                        send_request(MODE_ENQ_ORD, pick_ticket());
                end else begin
                    send_request(MODE_DEQ, pick_ticket());
                end
                sent++;
            end
        end
    endtask

    initial begin
        apply_reset();

        send_idle_pct = 23;
        recv_idle_pct = 81;
        test_basic_ops();
        test_full_classes();
        test_random_bursts(400);

        send_idle_pct = 81;
        recv_idle_pct = 23;
        test_random_bursts(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_bursts(400);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tcpq_pkg.sv
rtl/tcpq_store.sv
rtl/tcpq_ctrl.sv
rtl/two_class_priority_queue.sv
sim/tb_two_class_priority_queue.sv
